[rtl/core/clt_pkg.sv]
package clt_pkg;

    localparam int TOKEN_LIMIT     = 16;
    localparam int TOKEN_LEN_LIMIT = 64;

    // Counter widths follow from the limits above.
    localparam int TOK_CNT_W  = $clog2(TOKEN_LIMIT + 1);
    localparam int CHAR_CNT_W = $clog2(TOKEN_LEN_LIMIT);
    localparam int TOK_EXT_W  = (TOK_CNT_W > 5) ? TOK_CNT_W : 5;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b == CH_LOW_N) begin
            r = CH_NL;
        end else if (b == CH_LOW_T) begin
            r = CH_TAB;
        end
        return r;
    endfunction

endpackage

[rtl/core/command_line_tokenizer.sv]
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: in_byte[7:0]; tlast: line_last
// m_axis    out  tdata: tok_char[7:0], char_valid, token_done, token_number[3:0],
//                       tokens_in_line[4:0], zero fill; tlast: line_done
//
// One byte per cycle with no gaps while results are taken; each byte gives one result,
// which passes through the input register and then the result register.
// The lexer state advances as a byte moves into the result register.
// A stalled result holds the input register; a new byte is still taken in any
// cycle where the held byte moves on.
// Reset (synchronous, active low) empties both registers and clears the lexer.
module command_line_tokenizer
    import clt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // in_byte[7:0]
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // tok_char, char_valid, token_done,
                                                  // token_number, tokens_in_line, zeros
    output logic                  m_axis_tlast
);

    localparam logic [1:0] MODE_BETWEEN = 2'd0;
    localparam logic [1:0] MODE_WORD    = 2'd1;
    localparam logic [1:0] MODE_QUOTE   = 2'd2;
    localparam logic [1:0] MODE_FULL    = 2'd3;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    logic [1:0]            r_mode;
    logic                  r_quote_single;
    logic                  r_esc;
    logic [CHAR_CNT_W-1:0] r_chars;
    logic [TOK_CNT_W-1:0]  r_tokens;

    logic [1:0]            n_mode;
    logic                  n_quote_single;
    logic                  n_esc;
    logic [CHAR_CNT_W-1:0] n_chars;
    logic [TOK_CNT_W-1:0]  n_tokens;

    logic                  w_advance;
    logic                  w_blank;
    logic                  w_put;
    logic [7:0]            w_put_char;
    logic                  w_end;
    logic                  w_end_counted;
    logic [7:0]            w_tok_char;
    logic                  w_char_valid;
    logic                  w_token_done;
    logic [TOK_EXT_W-1:0]  w_old_ext;
    logic [TOK_EXT_W-1:0]  w_new_ext;
    logic [7:0]            w_close_quote;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    assign w_blank       = (r_in_byte == CH_SPACE) || (r_in_byte == CH_TAB);
    assign w_close_quote = r_quote_single ? CH_SQUOTE : CH_DQUOTE;

    always_comb begin
        n_mode         = r_mode;
        n_quote_single = r_quote_single;
        n_esc          = r_esc;
        n_chars        = r_chars;
        n_tokens       = r_tokens;
        w_put          = 1'b0;
        w_put_char     = r_in_byte;
        w_end          = 1'b0;
        w_end_counted  = 1'b0;
        w_tok_char     = 8'h00;
        w_char_valid   = 1'b0;
        w_token_done   = 1'b0;

        if (r_mode != MODE_FULL) begin
            if (r_esc) begin
                n_esc      = 1'b0;
                w_put      = 1'b1;
                w_put_char = unescape(r_in_byte);
            end else begin
                case (r_mode)
                    MODE_BETWEEN: begin
                        if (w_blank || r_in_byte == CH_NUL) begin
                            n_mode = r_mode;
                        end else if (r_in_byte == CH_DQUOTE || r_in_byte == CH_SQUOTE) begin
                            n_mode         = MODE_QUOTE;
                            n_quote_single = (r_in_byte == CH_SQUOTE);
                        end else begin
                            n_mode = MODE_WORD;
                            if (r_in_byte == CH_BSLASH && !r_in_last) begin
                                n_esc = 1'b1;
                            end else begin
                                w_put = 1'b1;
                            end
                        end
                    end
                    MODE_WORD: begin
                        if (w_blank || r_in_byte == CH_NUL) begin
                            w_end         = 1'b1;
                            w_end_counted = (r_chars != '0);
                        end else if (r_in_byte == CH_BSLASH && !r_in_last) begin
                            n_esc = 1'b1;
                        end else begin
                            w_put = 1'b1;
                        end
                    end
                    default: begin
                        if (r_in_byte == CH_BSLASH && !r_in_last) begin
                            n_esc = 1'b1;
                        end else if (r_in_byte == w_close_quote) begin
                            w_end         = 1'b1;
                            w_end_counted = 1'b1;
                        end else begin
                            w_put = 1'b1;
                        end
                    end
                endcase
            end

            // Characters past the 63rd of a token are dropped silently.
            if (w_put && r_chars < CHAR_CNT_W'(TOKEN_LEN_LIMIT - 1)) begin
                n_chars      = r_chars + 1'b1;
                w_tok_char   = w_put_char;
                w_char_valid = 1'b1;
            end

            // The end of the line closes an open word or quoted token.
            if (r_in_last && !w_end) begin
                if (n_mode == MODE_WORD) begin
                    w_end         = 1'b1;
                    w_end_counted = (n_chars != '0);
                end else if (n_mode == MODE_QUOTE) begin
                    w_end         = 1'b1;
                    w_end_counted = 1'b1;
                end
            end

            if (w_end) begin
                if (w_end_counted) begin
                    w_token_done = 1'b1;
                    n_tokens     = r_tokens + 1'b1;
                end
                n_chars        = '0;
                n_quote_single = 1'b0;
                n_mode = (n_tokens == TOK_CNT_W'(TOKEN_LIMIT)) ? MODE_FULL : MODE_BETWEEN;
            end
        end
    end

    assign w_old_ext = TOK_EXT_W'(r_tokens);
    assign w_new_ext = TOK_EXT_W'(n_tokens);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_mode         <= MODE_BETWEEN;
            r_quote_single <= 1'b0;
            r_esc          <= 1'b0;
            r_chars        <= '0;
            r_tokens       <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_advance) begin
                if (r_in_last) begin
                    r_mode         <= MODE_BETWEEN;
                    r_quote_single <= 1'b0;
                    r_esc          <= 1'b0;
                    r_chars        <= '0;
                    r_tokens       <= '0;
                end else begin
                    r_mode         <= n_mode;
                    r_quote_single <= n_quote_single;
                    r_esc          <= n_esc;
                    r_chars        <= n_chars;
                    r_tokens       <= n_tokens;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (w_advance) begin
            r_out_data <= {5'b00000, w_new_ext[4:0], w_old_ext[3:0],
                           w_token_done, w_char_valid, w_tok_char};
            r_out_last <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

[rtl/core/clt_checker.sv]
module clt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A dropped or empty character slot always carries a zero byte.
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("tok_char nonzero without char_valid");

    // A completed token's index is one below the running count.
    a_done_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[9])
            |-> (m_axis_tdata[13:10] == 4'(m_axis_tdata[17:14] - 4'd1)))
        else $error("token_number does not match completed count");

    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[9])
            |-> (m_axis_tdata[13:10] == m_axis_tdata[17:14]))
        else $error("token_number does not match count");

    // A new line starts at a zero count, so after a line end the next item
    // shows at most one completed token.
    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (!m_axis_tvalid || m_axis_tdata[18:15] == 4'd0))
        else $error("token count not cleared after line end");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("result changed while stalled");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (.*);
